@@ src/acs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and constants for the actuator command sequencer.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ParamW = 8;
  localparam int unsigned SensW  = 2;
  localparam int unsigned TimerW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // operation codes
  localparam logic [OpW-1:0] OP_TICK      = 3'd0;
  localparam logic [OpW-1:0] OP_KNOCK     = 3'd1;
  localparam logic [OpW-1:0] OP_ROTATE    = 3'd2;
  localparam logic [OpW-1:0] OP_DISCHARGE = 3'd3;
  localparam logic [OpW-1:0] OP_SENSOR    = 3'd4;

  // event kinds
  localparam logic [1:0] KIND_KNOCK_DONE     = 2'd0;
  localparam logic [1:0] KIND_ROTATE_DONE    = 2'd1;
  localparam logic [1:0] KIND_DISCHARGE_DONE = 2'd2;
  localparam logic [1:0] KIND_ERROR          = 2'd3;

  // error codes
  localparam logic [7:0] ERR_TIMEOUT = 8'd0;
  localparam logic [7:0] ERR_INVALID = 8'd1;
  localparam logic [7:0] ERR_BUSY    = 8'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_STRIKE_ANGLE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_REST_ANGLE        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DOOR_OPEN_ANGLE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DOOR_CLOSED_ANGLE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_SPEED       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROTATE_TIMEOUT    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_KNOCK_PERIOD      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DOOR_HOLD         = 3'd7;

  // fixed phase durations, ticks
  localparam logic [TimerW-1:0] STRIKE_DWELL_MS     = 16'd150;
  localparam logic [TimerW-1:0] STRIKE_SETTLE_MS    = 16'd150;
  localparam logic [TimerW-1:0] DOOR_SETTLE_TIME_MS = 16'd300;
  localparam logic [TimerW-1:0] STOP_SETTLE_MS      = 16'd200;

  typedef struct packed {
    logic [7:0]        strike_angle;
    logic [7:0]        rest_angle;
    logic [7:0]        door_open_deg;
    logic [7:0]        door_closed_angle;
    logic [7:0]        drive_speed;
    logic [TimerW-1:0] rotate_timeout_ms;
    logic [TimerW-1:0] knock_period_ms;
    logic [TimerW-1:0] door_hold_ticks;
  } acs_cfg_t;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] event_kind;
    logic [7:0] event_value;
    logic [7:0] knock_servo_angle;
    logic [7:0] door_servo_angle;
    logic [7:0] motor_duty;
    logic       busy_res;
  } acs_res_t;

endpackage

@@ src/acs_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_cmd_if / acs_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface acs_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] command_param;
  logic [1:0] sensor_position;

  modport source (output valid, output operation, output command_param,
                  output sensor_position, input ready);
  modport sink   (input valid, input operation, input command_param,
                  input sensor_position, output ready);
endinterface

interface acs_res_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [1:0] event_kind;
  logic [7:0] event_value;
  logic [7:0] knock_servo_angle;
  logic [7:0] door_servo_angle;
  logic [7:0] motor_duty;
  logic       busy_res;

  modport source (output valid, output event_valid, output event_kind,
                  output event_value, output knock_servo_angle,
                  output door_servo_angle, output motor_duty,
                  output busy_res, input ready);
  modport sink   (input valid, input event_valid, input event_kind,
                  input event_value, input knock_servo_angle,
                  input door_servo_angle, input motor_duty,
                  input busy_res, output ready);
endinterface

@@ src/acs_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module acs_cfg_regs
  import acs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output acs_cfg_t            cfg_o
);

  acs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STRIKE_ANGLE:      cfg_d.strike_angle      = cfg_data_i[7:0];
        REG_REST_ANGLE:        cfg_d.rest_angle        = cfg_data_i[7:0];
        REG_DOOR_OPEN_ANGLE:   cfg_d.door_open_deg     = cfg_data_i[7:0];
        REG_DOOR_CLOSED_ANGLE: cfg_d.door_closed_angle = cfg_data_i[7:0];
        REG_DRIVE_SPEED:       cfg_d.drive_speed       = cfg_data_i[7:0];
        REG_ROTATE_TIMEOUT:    cfg_d.rotate_timeout_ms = cfg_data_i[TimerW-1:0];
        REG_KNOCK_PERIOD:      cfg_d.knock_period_ms   = cfg_data_i[TimerW-1:0];
        REG_DOOR_HOLD:         cfg_d.door_hold_ticks   = cfg_data_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strike_angle      <= 8'd90;
      cfg_q.rest_angle        <= 8'd0;
      cfg_q.door_open_deg     <= 8'd90;
      cfg_q.door_closed_angle <= 8'd0;
      cfg_q.drive_speed       <= 8'd200;
      cfg_q.rotate_timeout_ms <= 16'd5000;
      cfg_q.knock_period_ms   <= 16'd500;
      cfg_q.door_hold_ticks   <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/acs_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_seq
// Command sequencer state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module acs_seq
  import acs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [OpW-1:0]    op_i,
  input  logic [ParamW-1:0] param_i,
  input  logic [SensW-1:0]  sensor_i,
  input  acs_cfg_t          cfg_i,
  output acs_res_t          res_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_K_DWELL  = 3'd1;
  localparam logic [2:0] PH_K_SETTLE = 3'd2;
  localparam logic [2:0] PH_K_WAIT   = 3'd3;
  localparam logic [2:0] PH_R_RUN    = 3'd4;
  localparam logic [2:0] PH_R_STOP   = 3'd5;
  localparam logic [2:0] PH_D_HOLD   = 3'd6;
  localparam logic [2:0] PH_D_SETTLE = 3'd7;

  localparam logic [TimerW-1:0] TimerMax = '1;
  localparam logic [2:0]        PosUnknown = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [TimerW-1:0] phase_tmr_q, phase_tmr_d;
  logic [TimerW-1:0] period_tmr_q, period_tmr_d;
  logic [7:0]        strikes_done_q, strikes_done_d;
  logic [7:0]        strikes_want_q, strikes_want_d;
  logic [1:0]        target_q, target_d;
  logic [2:0]        cur_pos_q, cur_pos_d;

  logic [TimerW-1:0] phase_inc, period_inc;
  logic [7:0]        strikes_inc;
  logic              ev_valid;
  logic [1:0]        ev_kind;
  logic [7:0]        ev_value;

  assign phase_inc   = (phase_tmr_q == TimerMax) ? phase_tmr_q : phase_tmr_q + 1'b1;
  assign period_inc  = (period_tmr_q == TimerMax) ? period_tmr_q : period_tmr_q + 1'b1;
  assign strikes_inc = strikes_done_q + 8'd1;

  always_comb begin
    phase_d        = phase_q;
    phase_tmr_d    = phase_tmr_q;
    period_tmr_d   = period_tmr_q;
    strikes_done_d = strikes_done_q;
    strikes_want_d = strikes_want_q;
    target_d       = target_q;
    cur_pos_d      = cur_pos_q;
    ev_valid       = 1'b0;
    ev_kind        = KIND_KNOCK_DONE;
    ev_value       = 8'd0;

    unique case (op_i)
      OP_TICK: begin
        if (phase_q != PH_IDLE) begin
          phase_tmr_d  = phase_inc;
          period_tmr_d = period_inc;
          unique case (phase_q)
            PH_K_DWELL: begin
              if (phase_inc >= STRIKE_DWELL_MS) begin
                phase_d     = PH_K_SETTLE;
                phase_tmr_d = '0;
              end
            end
            PH_K_SETTLE: begin
              if (phase_inc >= STRIKE_SETTLE_MS) begin
                strikes_done_d = strikes_inc;
                ev_valid       = 1'b1;
                ev_kind        = KIND_KNOCK_DONE;
                ev_value       = strikes_inc;
                phase_tmr_d    = '0;
                if (strikes_inc >= strikes_want_q) begin
                  phase_d = PH_IDLE;
                end else if (period_inc >= cfg_i.knock_period_ms) begin
                  phase_d      = PH_K_DWELL;
                  period_tmr_d = '0;
                end else begin
                  phase_d = PH_K_WAIT;
                end
              end
            end
            PH_K_WAIT: begin
              if (period_inc >= cfg_i.knock_period_ms) begin
                phase_d      = PH_K_DWELL;
                phase_tmr_d  = '0;
                period_tmr_d = '0;
              end
            end
            PH_R_RUN: begin
              if (phase_inc >= cfg_i.rotate_timeout_ms) begin
                phase_d     = PH_IDLE;
                phase_tmr_d = '0;
                ev_valid    = 1'b1;
                ev_kind     = KIND_ERROR;
                ev_value    = ERR_TIMEOUT;
              end
            end
            PH_R_STOP: begin
              if (phase_inc >= STOP_SETTLE_MS) begin
                phase_d     = PH_IDLE;
                phase_tmr_d = '0;
                ev_valid    = 1'b1;
                ev_kind     = KIND_ROTATE_DONE;
                ev_value    = {6'd0, target_q};
              end
            end
            PH_D_HOLD: begin
              if (phase_inc >= cfg_i.door_hold_ticks) begin
                phase_d     = PH_D_SETTLE;
                phase_tmr_d = '0;
              end
            end
            PH_D_SETTLE: begin
              if (phase_inc >= DOOR_SETTLE_TIME_MS) begin
                phase_d     = PH_IDLE;
                phase_tmr_d = '0;
                ev_valid    = 1'b1;
                ev_kind     = KIND_DISCHARGE_DONE;
                ev_value    = 8'd0;
              end
            end
            default: begin
              phase_d     = PH_IDLE;
              phase_tmr_d = '0;
            end
          endcase
        end
      end
      OP_KNOCK, OP_ROTATE, OP_DISCHARGE: begin
        if (phase_q != PH_IDLE) begin
          // running command carries on
          ev_valid = 1'b1;
          ev_kind  = KIND_ERROR;
          ev_value = ERR_BUSY;
        end else if (op_i == OP_KNOCK) begin
          if (param_i != 8'd0) begin
            strikes_want_d = param_i;
            strikes_done_d = 8'd0;
            phase_d        = PH_K_DWELL;
            phase_tmr_d    = '0;
            period_tmr_d   = '0;
          end
        end else if (op_i == OP_ROTATE) begin
          if (param_i > 8'd3) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_ERROR;
            ev_value = ERR_INVALID;
          end else if ({1'b0, param_i[1:0]} == cur_pos_q) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_ROTATE_DONE;
            ev_value = param_i;
          end else begin
            target_d    = param_i[1:0];
            phase_d     = PH_R_RUN;
            phase_tmr_d = '0;
          end
        end else begin
          phase_d     = PH_D_HOLD;
          phase_tmr_d = '0;
        end
      end
      OP_SENSOR: begin
        if (phase_q == PH_R_RUN && sensor_i == target_q) begin
          cur_pos_d   = {1'b0, target_q};
          phase_d     = PH_R_STOP;
          phase_tmr_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      phase_tmr_q    <= '0;
      period_tmr_q   <= '0;
      strikes_done_q <= '0;
      strikes_want_q <= '0;
      target_q       <= '0;
      cur_pos_q      <= PosUnknown;
    end else if (step_i) begin
      phase_q        <= phase_d;
      phase_tmr_q    <= phase_tmr_d;
      period_tmr_q   <= period_tmr_d;
      strikes_done_q <= strikes_done_d;
      strikes_want_q <= strikes_want_d;
      target_q       <= target_d;
      cur_pos_q      <= cur_pos_d;
    end
  end

  // outputs follow the state after the item
  always_comb begin
    res_o.event_valid       = ev_valid;
    res_o.event_kind        = ev_kind;
    res_o.event_value       = ev_value;
    res_o.knock_servo_angle = (phase_d == PH_K_DWELL) ? cfg_i.strike_angle
                                                      : cfg_i.rest_angle;
    res_o.door_servo_angle  = (phase_d == PH_D_HOLD) ? cfg_i.door_open_deg
                                                     : cfg_i.door_closed_angle;
    res_o.motor_duty        = (phase_d == PH_R_RUN) ? cfg_i.drive_speed : 8'd0;
    res_o.busy_res          = (phase_d != PH_IDLE);
  end

endmodule

@@ src/actuator_command_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_command_sequencer_top
// Knock, rotate and discharge sequencer driven by tick and sensor items.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i  - valid/ready channel of command items: a 1 ms tick, knock,
//            rotate, discharge or a position-sensor event.
//   res_o  - valid/ready channel, exactly one result item per command item,
//            carrying an optional report plus the servo angles, motor duty
//            and busy flag after that item.
//   cfg_*  - write port for the eight configuration registers.
// Each item is captured in an input register, stepped through the sequencer
// and held in the result register: res_o.valid rises once the stepped result
// is registered there. One item per cycle is sustained while the receiver
// takes results; the limit is the single state update per cycle in the
// sequencer.
// When the receiver stalls, the result register holds and the input register
// takes one more item before cmd_i.ready drops.
// Reset clears the pipeline, sets the sequencer idle with position unknown
// and loads the register defaults.
// ----------------------------------------------------------------------------
module actuator_command_sequencer_top
  import acs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  acs_cmd_if.sink             cmd_i,
  acs_res_if.source           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  acs_cfg_t cfg;
  acs_res_t step_res;

  logic              in_vld_q, in_vld_d;
  logic [OpW-1:0]    op_q;
  logic [ParamW-1:0] param_q;
  logic [SensW-1:0]  sensor_q;
  logic              out_vld_q, out_vld_d;
  acs_res_t          res_q;
  logic              step;
  logic              in_take;

  assign step     = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_take  = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = !in_vld_q || step;

  assign in_vld_d  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = step ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  acs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  acs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .op_i     (op_q),
    .param_i  (param_q),
    .sensor_i (sensor_q),
    .cfg_i    (cfg),
    .res_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= cmd_i.operation;
      param_q  <= cmd_i.command_param;
      sensor_q <= cmd_i.sensor_position;
    end
    if (step) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid             = out_vld_q;
  assign res_o.event_valid       = res_q.event_valid;
  assign res_o.event_kind        = res_q.event_kind;
  assign res_o.event_value       = res_q.event_value;
  assign res_o.knock_servo_angle = res_q.knock_servo_angle;
  assign res_o.door_servo_angle  = res_q.door_servo_angle;
  assign res_o.motor_duty        = res_q.motor_duty;
  assign res_o.busy_res          = res_q.busy_res;

`ifndef SYNTH
  // a busy rejection never stops the running command
  a_busy_keeps_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_valid && res_o.event_kind == KIND_ERROR &&
    res_o.event_value == ERR_BUSY |-> res_o.busy_res)
    else $error("busy rejection reported while idle");

  a_quiet_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.event_valid |->
    res_o.event_kind == KIND_KNOCK_DONE && res_o.event_value == 8'd0)
    else $error("report fields set without a report");

  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_valid && res_o.event_kind == KIND_ERROR |->
    res_o.event_value == ERR_TIMEOUT || res_o.event_value == ERR_INVALID ||
    res_o.event_value == ERR_BUSY)
    else $error("unknown error code");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped item lost before the result register");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the actuator command sequencer. A driver feeds
// command items from a queue with random gaps and a monitor checks every
// result item against an in-bench model of the sequencer. The run covers the
// reset register values, the low register extremes with a timeout and a
// repeated knock, and a stretch of random items under random register
// settings, with random stalls on the result side throughout.
// ----------------------------------------------------------------------------
module testbench;
  import acs_pkg::*;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [ParamW-1:0] param;
    logic [SensW-1:0]  sensor;
  } cmd_item_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_STRIKE, PH_STRIKE_SETTLE, PH_STRIKE_WAIT,
    PH_MOTOR_RUN, PH_MOTOR_STOP, PH_DOOR_HOLD, PH_DOOR_SETTLE
  } seq_phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  acs_cmd_if cmd_if ();
  acs_res_if res_if ();

  actuator_command_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the sequencer
  acs_cfg_t          reg_shadow;
  seq_phase_e        ph;
  logic [TimerW-1:0] ph_timer;
  logic [TimerW-1:0] per_timer;
  logic [7:0]        strikes_done;
  logic [7:0]        strikes_wanted;
  logic [1:0]        tgt_pos;
  logic [2:0]        cur_pos;

  cmd_item_t   pending_cmds[$];
  acs_res_t    predicted_outputs[$];
  int unsigned items_queued;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          cmd_took;
  bit          res_took;
  cmd_item_t   next_item;
  cmd_item_t   taken_item;
  acs_res_t    want;
  acs_res_t    got;

  function automatic acs_res_t advance_sequencer(input cmd_item_t c);
    acs_res_t r;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (ph != PH_IDLE) begin
          if (ph_timer != 16'hFFFF) ph_timer++;
          if (per_timer != 16'hFFFF) per_timer++;
          case (ph)
            PH_STRIKE: begin
              if (ph_timer >= STRIKE_DWELL_MS) begin
                ph = PH_STRIKE_SETTLE;
                ph_timer = '0;
              end
            end
            PH_STRIKE_SETTLE: begin
              if (ph_timer >= STRIKE_SETTLE_MS) begin
                strikes_done++;
                r.event_valid = 1'b1;
                r.event_kind  = KIND_KNOCK_DONE;
                r.event_value = strikes_done;
                if (strikes_done >= strikes_wanted) begin
                  ph = PH_IDLE;
                  ph_timer = '0;
                end else if (per_timer >= reg_shadow.knock_period_ms) begin
                  ph = PH_STRIKE;
                  ph_timer = '0;
                  per_timer = '0;
                end else begin
                  ph = PH_STRIKE_WAIT;
                  ph_timer = '0;
                end
              end
            end
            PH_STRIKE_WAIT: begin
              if (per_timer >= reg_shadow.knock_period_ms) begin
                ph = PH_STRIKE;
                ph_timer = '0;
                per_timer = '0;
              end
            end
            PH_MOTOR_RUN: begin
              if (ph_timer >= reg_shadow.rotate_timeout_ms) begin
                ph = PH_IDLE;
                ph_timer = '0;
                r.event_valid = 1'b1;
                r.event_kind  = KIND_ERROR;
                r.event_value = ERR_TIMEOUT;
              end
            end
            PH_MOTOR_STOP: begin
              if (ph_timer >= STOP_SETTLE_MS) begin
                ph = PH_IDLE;
                ph_timer = '0;
                r.event_valid = 1'b1;
                r.event_kind  = KIND_ROTATE_DONE;
                r.event_value = {6'd0, tgt_pos};
              end
            end
            PH_DOOR_HOLD: begin
              if (ph_timer >= reg_shadow.door_hold_ticks) begin
                ph = PH_DOOR_SETTLE;
                ph_timer = '0;
              end
            end
            PH_DOOR_SETTLE: begin
              if (ph_timer >= DOOR_SETTLE_TIME_MS) begin
                ph = PH_IDLE;
                ph_timer = '0;
                r.event_valid = 1'b1;
                r.event_kind  = KIND_DISCHARGE_DONE;
                r.event_value = 8'd0;
              end
            end
            default: begin
              ph = PH_IDLE;
              ph_timer = '0;
            end
          endcase
        end
      end
      OP_KNOCK, OP_ROTATE, OP_DISCHARGE: begin
        if (ph != PH_IDLE) begin
          r.event_valid = 1'b1;
          r.event_kind  = KIND_ERROR;
          r.event_value = ERR_BUSY;
        end else if (c.op == OP_KNOCK) begin
          // a count of zero leaves the block idle
          if (c.param != 8'd0) begin
            strikes_wanted = c.param;
            strikes_done = 8'd0;
            ph = PH_STRIKE;
            ph_timer = '0;
            per_timer = '0;
          end
        end else if (c.op == OP_ROTATE) begin
          if (c.param > 8'd3) begin
            r.event_valid = 1'b1;
            r.event_kind  = KIND_ERROR;
            r.event_value = ERR_INVALID;
          end else if (c.param == {5'd0, cur_pos}) begin
            r.event_valid = 1'b1;
            r.event_kind  = KIND_ROTATE_DONE;
            r.event_value = c.param;
          end else begin
            tgt_pos = c.param[1:0];
            ph = PH_MOTOR_RUN;
            ph_timer = '0;
          end
        end else begin
          ph = PH_DOOR_HOLD;
          ph_timer = '0;
        end
      end
      OP_SENSOR: begin
        if (ph == PH_MOTOR_RUN && c.sensor == tgt_pos) begin
          cur_pos = {1'b0, tgt_pos};
          ph = PH_MOTOR_STOP;
          ph_timer = '0;
        end
      end
      default: ;
    endcase
    r.knock_servo_angle = (ph == PH_STRIKE) ? reg_shadow.strike_angle : reg_shadow.rest_angle;
    r.door_servo_angle  = (ph == PH_DOOR_HOLD) ? reg_shadow.door_open_deg
                                               : reg_shadow.door_closed_angle;
    r.motor_duty        = (ph == PH_MOTOR_RUN) ? reg_shadow.drive_speed : 8'd0;
    r.busy_res          = (ph != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endtask

  // sample everything at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STRIKE_ANGLE:      reg_shadow.strike_angle      = cfg_data_i[7:0];
          REG_REST_ANGLE:        reg_shadow.rest_angle        = cfg_data_i[7:0];
          REG_DOOR_OPEN_ANGLE:   reg_shadow.door_open_deg     = cfg_data_i[7:0];
          REG_DOOR_CLOSED_ANGLE: reg_shadow.door_closed_angle = cfg_data_i[7:0];
          REG_DRIVE_SPEED:       reg_shadow.drive_speed       = cfg_data_i[7:0];
          REG_ROTATE_TIMEOUT:    reg_shadow.rotate_timeout_ms = cfg_data_i;
          REG_KNOCK_PERIOD:      reg_shadow.knock_period_ms   = cfg_data_i;
          REG_DOOR_HOLD:         reg_shadow.door_hold_ticks   = cfg_data_i;
          default: ;
        endcase
      end
      if (res_if.valid && res_if.ready) begin
        res_took = 1'b1;
        results_seen++;
        got = {res_if.event_valid, res_if.event_kind, res_if.event_value,
               res_if.knock_servo_angle, res_if.door_servo_angle,
               res_if.motor_duty, res_if.busy_res};
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          $display("%0t ns: result item with nothing expected", $time);
        end else begin
          want = predicted_outputs.pop_front();
          check_field("event_valid", want.event_valid, got.event_valid);
          check_field("event_kind", want.event_kind, got.event_kind);
          check_field("event_value", want.event_value, got.event_value);
          check_field("knock_servo_angle", want.knock_servo_angle, got.knock_servo_angle);
          check_field("door_servo_angle", want.door_servo_angle, got.door_servo_angle);
          check_field("motor_duty", want.motor_duty, got.motor_duty);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        cmd_took = 1'b1;
        taken_item = {cmd_if.operation, cmd_if.command_param, cmd_if.sensor_position};
        predicted_outputs.push_back(advance_sequencer(taken_item));
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    if (!cmd_if.valid || cmd_took) begin
      cmd_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_item = pending_cmds.pop_front();
        cmd_if.operation       <= next_item.op;
        cmd_if.command_param   <= next_item.param;
        cmd_if.sensor_position <= next_item.sensor;
        cmd_if.valid           <= 1'b1;
        gap_left = $urandom_range(0, gap_max);
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure, one draw per result item
  always @(negedge clk_i) begin
    if (res_took) begin
      res_took = 1'b0;
      stall_left = $urandom_range(0, stall_max);
    end
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic queue_item(input logic [OpW-1:0] op, input logic [ParamW-1:0] param,
                            input logic [SensW-1:0] sensor);
    pending_cmds.push_back({op, param, sensor});
    items_queued++;
  endtask

  task automatic queue_noise();
    queue_item(3'($urandom_range(1, 7)), 8'($urandom), 2'($urandom));
  endtask

  // ticks with the odd stray item mixed in
  task automatic queue_ticks(input int unsigned n, input bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 59) == 0) queue_noise();
      queue_item(OP_TICK, 8'($urandom), 2'($urandom));
    end
  endtask

  // a mix of ticks, sensor events and commands
  task automatic queue_random(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) queue_item(OP_TICK, 8'($urandom), 2'($urandom));
      else if (pick < 7) queue_item(OP_SENSOR, 8'($urandom), 2'($urandom));
      else queue_noise();
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  // upper bits of the byte-wide registers carry junk that must be dropped
  task automatic load_registers(input acs_cfg_t c);
    write_reg(REG_STRIKE_ANGLE,      {8'($urandom), c.strike_angle});
    write_reg(REG_REST_ANGLE,        {8'($urandom), c.rest_angle});
    write_reg(REG_DOOR_OPEN_ANGLE,   {8'($urandom), c.door_open_deg});
    write_reg(REG_DOOR_CLOSED_ANGLE, {8'($urandom), c.door_closed_angle});
    write_reg(REG_DRIVE_SPEED,       {8'($urandom), c.drive_speed});
    write_reg(REG_ROTATE_TIMEOUT,    c.rotate_timeout_ms);
    write_reg(REG_KNOCK_PERIOD,      c.knock_period_ms);
    write_reg(REG_DOOR_HOLD,         c.door_hold_ticks);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (results_seen == items_queued);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_angle();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(181, 255));
    return 8'($urandom_range(0, 180));
  endfunction

  function automatic acs_cfg_t random_registers();
    acs_cfg_t c;
    c.strike_angle      = pick_angle();
    c.rest_angle        = pick_angle();
    c.door_open_deg     = pick_angle();
    c.door_closed_angle = pick_angle();
    c.drive_speed       = 8'($urandom);
    c.rotate_timeout_ms = 16'($urandom_range(0, 400));
    c.knock_period_ms   = 16'($urandom_range(0, 500));
    c.door_hold_ticks   = 16'($urandom_range(0, 300));
    return c;
  endfunction

  initial begin
    acs_cfg_t c;
    cmd_if.valid           = 1'b0;
    cmd_if.operation       = OP_TICK;
    cmd_if.command_param   = '0;
    cmd_if.sensor_position = '0;
    res_if.ready           = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_index_i            = REG_STRIKE_ANGLE;
    cfg_data_i             = '0;
    reg_shadow = '{strike_angle: 8'd90, rest_angle: 8'd0, door_open_deg: 8'd90,
                   door_closed_angle: 8'd0, drive_speed: 8'd200,
                   rotate_timeout_ms: 16'd5000, knock_period_ms: 16'd500,
                   door_hold_ticks: 16'd1000};
    ph = PH_IDLE;
    ph_timer = '0;
    per_timer = '0;
    strikes_done = '0;
    strikes_wanted = '0;
    tgt_pos = '0;
    cur_pos = 3'd4;
    items_queued = 0;
    results_seen = 0;
    mismatches = 0;
    gap_left = 0;
    stall_left = 0;
    cmd_took = 1'b0;
    res_took = 1'b0;
    gap_max = 10;
    stall_max = 10;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: stray ops, invalid targets, busy rejection, sensor stop
    queue_item(3'd5, 8'd0, 2'd0);
    queue_item(3'd6, 8'd0, 2'd1);
    queue_item(3'd7, 8'd255, 2'd3);
    queue_item(OP_SENSOR, 8'd0, 2'd2);
    queue_ticks(2, 1'b0);
    queue_item(OP_ROTATE, 8'd255, 2'd0);
    queue_item(OP_ROTATE, 8'd4, 2'd0);
    queue_item(OP_KNOCK, 8'd0, 2'd0);
    queue_item(OP_ROTATE, 8'd3, 2'd0);
    queue_item(OP_SENSOR, 8'd0, 2'd1);
    queue_item(OP_KNOCK, 8'd170, 2'd0);
    queue_item(OP_DISCHARGE, 8'd0, 2'd0);
    queue_item(OP_ROTATE, 8'd85, 2'd0);
    queue_item(OP_SENSOR, 8'd255, 2'd3);
    queue_ticks(205, 1'b0);
    queue_item(OP_ROTATE, 8'd3, 2'd0);
    // left running into the next register set
    queue_item(OP_ROTATE, 8'd0, 2'd0);
    queue_ticks(3, 1'b0);
    queue_item(OP_SENSOR, 8'd0, 2'd2);
    wait_drained();

    // low extremes: zero timeout ends the running rotate, zero period
    // restarts the knock at once
    load_registers('{strike_angle: 8'd180, rest_angle: 8'd0, door_open_deg: 8'd180,
                     door_closed_angle: 8'd0, drive_speed: 8'd255,
                     rotate_timeout_ms: 16'd0, knock_period_ms: 16'd0,
                     door_hold_ticks: 16'd0});
    queue_ticks(1, 1'b0);
    queue_item(OP_KNOCK, 8'd2, 2'd0);
    queue_ticks(305, 1'b1);
    queue_item(OP_DISCHARGE, 8'd0, 2'd0);
    wait_drained();

    // random settings and a random mix of items
    c = random_registers();
    load_registers(c);
    queue_random(70);
    wait_drained();

    wait (results_seen == items_queued);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
src/acs_pkg.sv
src/acs_cmd_if.sv
src/acs_cfg_regs.sv
src/acs_seq.sv
src/actuator_command_sequencer_top.sv
bench/testbench.sv
